FILE: src/mcsp_pkg.sv
// Shared types, codes and reset values for the servo pulse generator.
package mcsp_pkg;

    localparam int PIN_W   = 8;
    localparam int LEN_W   = 20;
    localparam int SLOT_LEN_W = 16;
    localparam int POS_W   = 8;
    localparam int CHAN_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [POS_W-1:0] POS_RESET = 8'd100;

    localparam logic [PIN_W-1:0]      ENABLE_RESET = 8'd255;
    localparam logic [LEN_W-1:0]      LOW_RESET    = 20'd960000;
    localparam logic [LEN_W-1:0]      HIGH_RESET   = 20'd28800;
    localparam logic [SLOT_LEN_W-1:0] SLOT_RESET   = 16'd312;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS  = 2'd3;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_SET_POS = 1'b1;

    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_POS  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PIN_W-1:0]      enable_mask;
        logic [LEN_W-1:0]      low_ticks;
        logic [LEN_W-1:0]      high_ticks;
        logic [SLOT_LEN_W-1:0] slot_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        phase_t           phase;
        logic             frame_start;
    } result_t;

endpackage

FILE: src/mcsp_stream_if.sv
// Valid/ready channel interfaces for input items and result items.
interface mcsp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [2:0] channel;
    logic [7:0] position;

    modport source (output valid, output mode, output channel, output position, input ready);
    modport sink   (input valid, input mode, input channel, input position, output ready);
endinterface

interface mcsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pin_levels;
    logic [1:0] phase;
    logic       frame_start;

    modport source (output valid, output pin_levels, output phase, output frame_start,
                    input ready);
    modport sink   (input valid, input pin_levels, input phase, input frame_start,
                    output ready);
endinterface

FILE: src/multi_channel_servo_pulse_generator_top.sv
// Eight-channel servo pulse generator: configuration, handshake and result register.
// The result is registered: it is valid in the output register in the cycle after the input transfer.
// Throughput: one item per cycle; a new item is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset (rst_n, asynchronous, active low): low gap phase, counters zero, pins low,
// every channel position 100, configuration registers at their default values.
module multi_channel_servo_pulse_generator_top #(
    parameter int CHANNELS = 8,
    parameter int SLOTS    = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mcsp_in_if.sink                           in_ch,
    mcsp_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [mcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mcsp_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [PIN_W-1:0] CH_MASK = PIN_W'((1 << CHANNELS) - 1);

    cfg_t              cfg_reg;
    result_t           res_next;
    result_t           out_reg;
    logic              out_valid_reg;
    logic              accept;
    logic              tick_step;
    logic              pos_write;
    logic [PIN_W-1:0]  match;
    logic [SLOT_W-1:0] slot_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask <= ENABLE_RESET;
            cfg_reg.low_ticks   <= LOW_RESET;
            cfg_reg.high_ticks  <= HIGH_RESET;
            cfg_reg.slot_ticks  <= SLOT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE_MASK: cfg_reg.enable_mask <= cfg_data[PIN_W-1:0];
                CFG_LOW_TICKS:   cfg_reg.low_ticks   <= cfg_data[LEN_W-1:0];
                CFG_HIGH_TICKS:  cfg_reg.high_ticks  <= cfg_data[LEN_W-1:0];
                CFG_SLOT_TICKS:  cfg_reg.slot_ticks  <= cfg_data[SLOT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign tick_step   = accept && (in_ch.mode == MODE_TICK);
    // Channels beyond the bank are ignored
    assign pos_write   = accept && (in_ch.mode == MODE_SET_POS)
                         && ({1'b0, in_ch.channel} < (CHAN_W+1)'(CHANNELS));

    mcsp_chan_bank #(
        .CHANNELS (CHANNELS),
        .SLOT_W   (SLOT_W)
    ) u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (pos_write),
        .channel    (in_ch.channel),
        .position   (in_ch.position),
        .slot_index (slot_index),
        .match      (match)
    );

    mcsp_frame_seq #(
        .CHANNELS (CHANNELS),
        .SLOTS    (SLOTS),
        .SLOT_W   (SLOT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (tick_step),
        .match      (match),
        .slot_index (slot_index),
        .res_next   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pin_levels  = out_reg.pin_levels;
    assign out_ch.phase       = 2'(out_reg.phase);
    assign out_ch.frame_start = out_reg.frame_start;

`ifndef SYNTHESIS
    a_start_in_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_start |-> out_ch.phase == 2'(PH_HIGH))
        else $error("frame start outside the minimum high phase");

    a_low_pins_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.phase == 2'(PH_LOW) |-> out_ch.pin_levels == '0)
        else $error("pin high during the low gap");

    a_unused_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.pin_levels & ~CH_MASK) == '0)
        else $error("pin beyond the channel count driven");

    a_set_pos_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.mode == MODE_SET_POS |=> out_ch.valid && !out_ch.frame_start)
        else $error("position update produced a frame start");
`endif

endmodule

FILE: src/mcsp_chan_bank.sv
// Per-channel position registers with slot comparators.
module mcsp_chan_bank #(
    parameter int CHANNELS = 8,
    parameter int SLOT_W   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [mcsp_pkg::CHAN_W-1:0]   channel,
    input  logic [mcsp_pkg::POS_W-1:0]    position,
    input  logic [SLOT_W-1:0]             slot_index,
    output logic [mcsp_pkg::PIN_W-1:0]    match
);
    import mcsp_pkg::*;

    logic [POS_W-1:0] pos_reg [CHANNELS];
    logic [POS_W-1:0] slot_ext;

    assign slot_ext = POS_W'(slot_index);

    for (genvar c = 0; c < PIN_W; c++) begin : g_lane
        if (c < CHANNELS) begin : g_used
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pos_reg[c] <= POS_RESET;
                end
                else if (wr_en && (channel == CHAN_W'(c)))
                begin
                    pos_reg[c] <= position;
                end
            end

            assign match[c] = (pos_reg[c] == slot_ext);
        end
        else begin : g_unused
            assign match[c] = 1'b0;
        end
    end

endmodule

FILE: src/mcsp_frame_seq.sv
// Frame sequencer: tick counter, slot counter, phase and pin levels.
module mcsp_frame_seq #(
    parameter int CHANNELS = 8,
    parameter int SLOTS    = 256,
    parameter int SLOT_W   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcsp_pkg::cfg_t                cfg,
    input  logic                          step,
    input  logic [mcsp_pkg::PIN_W-1:0]    match,
    output logic [SLOT_W-1:0]             slot_index,
    output mcsp_pkg::result_t             res_next
);
    import mcsp_pkg::*;

    localparam logic [PIN_W-1:0] CH_MASK = PIN_W'((1 << CHANNELS) - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   tick_reg, tick_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [PIN_W-1:0]   pin_reg, pin_next;
    logic               start;

    logic [LEN_W-1:0]   period_len;
    logic [LEN_W-1:0]   period_eff;
    logic [LEN_W:0]     tick_sum;
    logic               period_done;
    logic               last_slot;

    always_comb
    begin
        case (phase_reg)
            PH_HIGH: period_len = cfg.high_ticks;
            PH_POS:  period_len = LEN_W'(cfg.slot_ticks);
            default: period_len = cfg.low_ticks;
        endcase
    end

    // A zero length acts as one tick
    assign period_eff  = (period_len == '0) ? LEN_W'(1) : period_len;
    assign tick_sum    = {1'b0, tick_reg} + (LEN_W+1)'(1);
    assign period_done = (tick_sum >= {1'b0, period_eff});
    assign last_slot   = (slot_reg == LAST_SLOT);

    always_comb
    begin
        phase_next = phase_reg;
        if (step && period_done)
        begin
            case (phase_reg)
                PH_HIGH: phase_next = PH_POS;
                PH_POS:  phase_next = last_slot ? PH_LOW : PH_POS;
                default: phase_next = PH_HIGH;
            endcase
        end
    end

    always_comb
    begin
        tick_next = tick_reg;
        slot_next = slot_reg;
        pin_next  = pin_reg;
        start     = 1'b0;
        if (step)
        begin
            if (period_done)
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_HIGH:
                    begin
                        slot_next = '0;
                    end
                    PH_POS:
                    begin
                        // Drop enabled pins whose position ends at this slot
                        pin_next = pin_reg & ~(match & cfg.enable_mask & CH_MASK);
                        if (last_slot)
                        begin
                            slot_next = '0;
                            pin_next  = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + SLOT_W'(1);
                        end
                    end
                    default:
                    begin
                        pin_next = cfg.enable_mask & CH_MASK;
                        start    = 1'b1;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_sum[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOW;
            tick_reg  <= '0;
            slot_reg  <= '0;
            pin_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            slot_reg  <= slot_next;
            pin_reg   <= pin_next;
        end
    end

    assign slot_index           = slot_reg;
    assign res_next.pin_levels  = pin_next;
    assign res_next.phase       = phase_next;
    assign res_next.frame_start = start;

endmodule

FILE: dv/multi_channel_servo_pulse_generator_top_tb.sv
// Self-checking testbench for the eight-channel servo pulse generator.
`timescale 1ns / 1ps

module multi_channel_servo_pulse_generator_top_tb;
    import mcsp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int CHANNELS     = 8;
    localparam int SLOTS        = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam int ROUND_ITEMS  = 190;
    localparam int REPORT_LIMIT = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcsp_in_if  in_bus ();
    mcsp_out_if out_bus ();

    multi_channel_servo_pulse_generator_top #(
        .CHANNELS(CHANNELS),
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_bus),
        .out_ch(out_bus),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow of the generator: configuration, timers, positions and pins
    cfg_t             shadow_cfg;
    phase_t           model_phase;
    logic [LEN_W-1:0] model_ticks;
    logic [POS_W-1:0] model_slot;
    logic [POS_W-1:0] model_pos [CHANNELS];
    logic [PIN_W-1:0] model_pins;

    result_t     pin_forecast [$];
    int unsigned mismatch_count = 0;
    bit          in_quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic void reset_model();
        shadow_cfg.enable_mask = ENABLE_RESET;
        shadow_cfg.low_ticks   = LOW_RESET;
        shadow_cfg.high_ticks  = HIGH_RESET;
        shadow_cfg.slot_ticks  = SLOT_RESET;
        model_phase = PH_LOW;
        model_ticks = '0;
        model_slot  = '0;
        model_pins  = '0;
        for (int c = 0; c < CHANNELS; c++)
            model_pos[c] = POS_RESET;
    endfunction

    // A length of zero behaves as one tick
    function automatic logic [LEN_W:0] period_length();
        logic [LEN_W-1:0] len;
        case (model_phase)
            PH_HIGH: len = shadow_cfg.high_ticks;
            PH_POS:  len = LEN_W'(shadow_cfg.slot_ticks);
            default: len = shadow_cfg.low_ticks;
        endcase
        return (len == '0) ? (LEN_W + 1)'(1) : {1'b0, len};
    endfunction

    function automatic result_t servo_step(logic mode, logic [CHAN_W-1:0] chan,
                                           logic [POS_W-1:0] pos);
        result_t          r;
        logic [LEN_W:0]   next_ticks;
        logic [PIN_W-1:0] drop;
        logic [PIN_W-1:0] chan_bits;
        logic             started;
        started   = 1'b0;
        chan_bits = PIN_W'((1 << CHANNELS) - 1);
        if (mode == MODE_SET_POS)
        begin
            if (int'(chan) < CHANNELS)
                model_pos[chan] = pos;
        end
        else
        begin
            next_ticks = {1'b0, model_ticks} + 1'b1;
            if (next_ticks >= period_length())
            begin
                model_ticks = '0;
                case (model_phase)
                    PH_HIGH:
                    begin
                        model_phase = PH_POS;
                        model_slot  = '0;
                    end
                    PH_POS:
                    begin
                        drop = '0;
                        for (int c = 0; c < CHANNELS; c++)
                            if (model_pos[c] == model_slot)
                                drop[c] = 1'b1;
                        drop &= shadow_cfg.enable_mask & chan_bits;
                        model_pins &= ~drop;
                        if (int'(model_slot) + 1 >= SLOTS)
                        begin
                            model_slot  = '0;
                            model_phase = PH_LOW;
                            model_pins  = '0;
                        end
                        else
                        begin
                            model_slot = model_slot + 1'b1;
                        end
                    end
                    default:
                    begin
                        // end of the low gap, also taken for an unknown phase code
                        model_pins  = shadow_cfg.enable_mask & chan_bits;
                        model_phase = PH_HIGH;
                        started     = 1'b1;
                    end
                endcase
            end
            else
            begin
                model_ticks = next_ticks[LEN_W-1:0];
            end
        end
        r.pin_levels  = model_pins;
        r.phase       = model_phase;
        r.frame_start = started;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_item(logic mode, logic [CHAN_W-1:0] chan, logic [POS_W-1:0] pos);
        int gap;
        if ($urandom_range(0, 49) == 0)
            in_quiet = !in_quiet;
        gap = pick_gap(in_quiet);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.mode     <= mode;
        in_bus.channel  <= chan;
        in_bus.position <= pos;
        do
            @(posedge clk);
        while (!in_bus.ready);
        pin_forecast.push_back(servo_step(mode, chan, pos));
    endtask

    task automatic tick();
        send_item(MODE_TICK, CHAN_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold until every transfer has produced its result
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pin_forecast.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_config(logic [PIN_W-1:0] mask, logic [LEN_W-1:0] low,
                               logic [LEN_W-1:0] high, logic [SLOT_LEN_W-1:0] slot);
        write_reg(CFG_ENABLE_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_LOW_TICKS, CFG_DATA_W'(low));
        write_reg(CFG_HIGH_TICKS, CFG_DATA_W'(high));
        write_reg(CFG_SLOT_TICKS, CFG_DATA_W'(slot));
        cfg_we <= 1'b0;
        shadow_cfg.enable_mask = mask;
        shadow_cfg.low_ticks   = low;
        shadow_cfg.high_ticks  = high;
        shadow_cfg.slot_ticks  = slot;
    endtask

    // Result sink with random stalls and stretches without any
    initial
    begin
        int stall;
        bit quiet;
        stall = 0;
        quiet = 1'b0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                quiet = !quiet;
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_bus.ready <= 1'b1;
                stall = pick_gap(quiet);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (pin_forecast.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with none pending: pins %h phase %0d start %0b",
                             $time, out_bus.pin_levels, out_bus.phase, out_bus.frame_start);
            end
            else
            begin
                want = pin_forecast.pop_front();
                if (out_bus.pin_levels !== want.pin_levels || out_bus.phase !== want.phase
                    || out_bus.frame_start !== want.frame_start)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: expected pins %h phase %0d start %0b, got %h %0d %0b",
                                 $time, want.pin_levels, want.phase, want.frame_start,
                                 out_bus.pin_levels, out_bus.phase, out_bus.frame_start);
                end
            end
        end
    end

    // Reset configuration: field extremes on ticks, positions set in the low gap
    task automatic test_reset_state();
        send_item(MODE_TICK, 3'd7, 8'hFF);
        send_item(MODE_SET_POS, 3'd0, 8'd0);
        send_item(MODE_SET_POS, 3'd7, 8'd255);
        send_item(MODE_SET_POS, 3'd2, 8'd2);
        send_item(MODE_TICK, 3'd0, 8'd0);
        wait_idle();
    endtask

    // Zero lengths act as one tick; the low gap is already past its new length
    task automatic test_zero_lengths();
        load_config(8'hA5, '0, '0, '0);
        repeat (4) tick();
        send_item(MODE_SET_POS, 3'd5, model_slot);
        repeat (2) tick();
        wait_idle();
    endtask

    // A pin already high survives its channel being disabled
    task automatic test_disable_mid_pulse();
        send_item(MODE_SET_POS, 3'd7, model_slot + 1'b1);
        wait_idle();
        load_config(8'h00, '0, '0, '0);
        repeat (3) tick();
        wait_idle();
    endtask

    // Longest periods, then cut short below the ticks already spent
    task automatic test_extreme_lengths();
        load_config(8'hFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        repeat (3) tick();
        wait_idle();
        load_config(8'hFF, 20'd1, 20'd1, 16'd1);
        repeat (2) tick();
        wait_idle();
    endtask

    task automatic test_random_frames();
        logic [PIN_W-1:0]      mask;
        logic [LEN_W-1:0]      low;
        logic [LEN_W-1:0]      high;
        logic [SLOT_LEN_W-1:0] slot;
        for (int round = 0; round < 4; round++)
        begin
            low  = LEN_W'($urandom_range(1, 8));
            high = LEN_W'($urandom_range(1, 8));
            slot = 16'd1;
            case (round)
                0: mask = 8'hFF;
                1:
                begin
                    mask = PIN_W'($urandom);
                    low  = '0;
                    high = '0;
                    slot = '0;
                end
                2:
                begin
                    mask = 8'h00;
                    slot = SLOT_LEN_W'($urandom_range(1, 3));
                end
                default: mask = PIN_W'($urandom_range(1, 254));
            endcase
            load_config(mask, low, high, slot);
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // aim half the updates at or just ahead of the running slot
                    if ($urandom_range(0, 1) == 0)
                        send_item(MODE_SET_POS, CHAN_W'($urandom_range(0, 7)),
                                  POS_W'($urandom_range(0, 255)));
                    else
                        send_item(MODE_SET_POS, CHAN_W'($urandom_range(0, 7)),
                                  model_slot + POS_W'($urandom_range(0, 3)));
                end
                else
                begin
                    tick();
                end
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_ENABLE_MASK;
        cfg_data        <= '0;
        in_bus.valid    <= 1'b0;
        in_bus.mode     <= MODE_TICK;
        in_bus.channel  <= '0;
        in_bus.position <= '0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_lengths();
        test_disable_mid_pulse();
        test_extreme_lengths();
        test_random_frames();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pin_forecast.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
src/mcsp_pkg.sv
src/mcsp_stream_if.sv
src/mcsp_chan_bank.sv
src/mcsp_frame_seq.sv
src/multi_channel_servo_pulse_generator_top.sv
dv/multi_channel_servo_pulse_generator_top_tb.sv
